[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the rtl; compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/sexl_pkg.sv]
// ----------------------------------------------------------------------------
// sexl_pkg
// types, character codes and helpers of the s-expression lexer
// ----------------------------------------------------------------------------
package sexl_pkg;

    // default symbol length limit
    localparam int MAX_SYMBOL_LEN_DEF = 127;

    // result queue depth
    localparam int RQ_DEPTH = 4;

    // largest integer value
    localparam logic [30:0] NUM_MAX = 31'h7fff_ffff;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5a;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7a;

    typedef enum logic [1:0] {
        LEX_IDLE,
        LEX_NUMBER,
        LEX_SYMBOL,
        LEX_ERROR
    } t_lex_mode;

    typedef enum logic [3:0] {
        K_LPAREN  = 4'd0,
        K_RPAREN  = 4'd1,
        K_DOT     = 4'd2,
        K_QUOTE   = 4'd3,
        K_INTEGER = 4'd4,
        K_SYMCHAR = 4'd5,
        K_SYMEND  = 4'd6,
        K_END     = 4'd7,
        K_ERROR   = 4'd8
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [30:0] number_value;
        logic [7:0]  symbol_char;
        logic [6:0]  symbol_length;
        logic        last;
    } t_result;

    // build a result with last cleared
    function automatic t_result mk_res(t_kind kind, logic [30:0] num,
                                       logic [7:0] ch, logic [6:0] len);
        t_result r;
        r.kind          = kind;
        r.number_value  = num;
        r.symbol_char   = ch;
        r.symbol_length = len;
        r.last          = 1'b0;
        return r;
    endfunction

endpackage

[hw/rtl/sexl_in_if.sv]
// ----------------------------------------------------------------------------
// sexl_in_if
// text byte channel of the s-expression lexer
// ----------------------------------------------------------------------------
interface sexl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

[hw/rtl/sexl_out_if.sv]
// ----------------------------------------------------------------------------
// sexl_out_if
// token channel of the s-expression lexer
// ----------------------------------------------------------------------------
interface sexl_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [30:0] number_value;
    logic [7:0]  symbol_char;
    logic [6:0]  symbol_length;
    logic        last;

    modport source (output valid, output kind, output number_value,
                    output symbol_char, output symbol_length, output last,
                    input ready);
    modport sink   (input valid, input kind, input number_value,
                    input symbol_char, input symbol_length, input last,
                    output ready);
endinterface

[hw/rtl/sexpr_tokenizer_unit.sv]
// ----------------------------------------------------------------------------
// sexpr_tokenizer_unit
// s-expression lexer: one text byte in, up to two token items out
// ----------------------------------------------------------------------------
// i_char carries one text byte per item; a zero byte ends the text.
// o_tok carries token items: kind, integer value, symbol byte or offending
// byte, symbol length and a last flag on the final item caused by a byte.
// Each accepted byte is lexed in the cycle it is taken, and its items are
// written into a four-entry result queue; o_tok shows the oldest queued item,
// so the first of them is shown in the next cycle if the queue was empty.
// Throughput is one byte per cycle while i_char.ready is high. A byte that
// closes a token and also emits an item of its own gives two items, which
// leave o_tok one after the other; the result queue absorbs this.
// i_char.ready is high while the result queue has room for two items, so
// a stalled receiver fills the queue and then holds off the input; nothing
// is lost or repeated.
// Reset empties the queue and returns the lexer to idle with the integer
// accumulator and symbol count cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sexpr_tokenizer_unit #(
    parameter int MAX_SYMBOL_LEN = sexl_pkg::MAX_SYMBOL_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sexl_in_if.sink           i_char,
    sexl_out_if.source        o_tok
);
    import sexl_pkg::*;

    localparam int CW = $clog2(MAX_SYMBOL_LEN + 1);
    localparam int PW = $clog2(RQ_DEPTH);
    localparam int QW = $clog2(RQ_DEPTH + 1);

    t_lex_mode        r_mode, n_mode;
    logic [30:0]      r_acc, n_acc;
    logic [CW-1:0]    r_sym_cnt, n_sym_cnt;

    t_result          r_queue [RQ_DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [QW-1:0]    r_count, n_count;

    logic             accept, pop;
    logic [7:0]       c;
    logic             is_digit, is_alpha, is_sign, is_space, is_symch;
    logic [34:0]      acc_x10;

    // idle-mode lexing of the current byte
    logic             idle_hit;
    t_result          idle_res;
    t_lex_mode        idle_mode;
    logic [30:0]      idle_acc;
    logic [CW-1:0]    idle_cnt;

    // results of this byte
    logic [1:0]       res_n;
    t_result          res_a, res_b;

    assign accept = i_char.valid && i_char.ready;
    assign pop    = o_tok.valid && o_tok.ready;
    assign c      = i_char.char_code;

    // character classes
    assign is_digit = c inside {[CH_ZERO:CH_NINE]};
    assign is_alpha = c inside {[CH_UC_A:CH_UC_Z], [CH_LC_A:CH_LC_Z]};
    assign is_sign  = c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    assign is_space = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    assign is_symch = is_alpha || is_digit || is_sign;

    // accumulator times ten plus digit, by shifts and adds
    assign acc_x10 = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                   + {27'b0, c - CH_ZERO};

    // lexing from idle
    always_comb begin
        idle_hit  = 1'b0;
        idle_res  = mk_res(K_END, '0, '0, '0);
        idle_mode = LEX_IDLE;
        idle_acc  = '0;
        idle_cnt  = '0;
        if (c == CH_NUL) begin
            idle_hit = 1'b1;
        end else if (is_space) begin
            idle_hit = 1'b0;
        end else if (c == CH_LPAREN) begin
            idle_hit = 1'b1;
            idle_res = mk_res(K_LPAREN, '0, '0, '0);
        end else if (c == CH_RPAREN) begin
            idle_hit = 1'b1;
            idle_res = mk_res(K_RPAREN, '0, '0, '0);
        end else if (c == CH_DOT) begin
            idle_hit = 1'b1;
            idle_res = mk_res(K_DOT, '0, '0, '0);
        end else if (c == CH_QUOTE) begin
            idle_hit = 1'b1;
            idle_res = mk_res(K_QUOTE, '0, '0, '0);
        end else if (is_digit) begin
            idle_acc  = {27'b0, 4'(c - CH_ZERO)};
            idle_mode = LEX_NUMBER;
        end else if (is_alpha || is_sign) begin
            idle_hit  = 1'b1;
            idle_res  = mk_res(K_SYMCHAR, '0, c, '0);
            idle_cnt  = CW'(1);
            idle_mode = LEX_SYMBOL;
        end else begin
            idle_hit  = 1'b1;
            idle_res  = mk_res(K_ERROR, '0, c, '0);
            idle_mode = LEX_ERROR;
        end
    end

    // lexer state update and results of the byte
    always_comb begin
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_sym_cnt = r_sym_cnt;
        res_n     = 2'd0;
        res_a     = idle_res;
        res_b     = idle_res;
        case (r_mode)
            LEX_NUMBER: begin
                if (is_digit) begin
                    n_acc = (acc_x10 > {4'b0, NUM_MAX}) ? NUM_MAX : acc_x10[30:0];
                end else begin
                    res_a     = mk_res(K_INTEGER, r_acc, '0, '0);
                    res_n     = idle_hit ? 2'd2 : 2'd1;
                    n_mode    = idle_mode;
                    n_acc     = idle_acc;
                    n_sym_cnt = idle_cnt;
                end
            end
            LEX_SYMBOL: begin
                if (is_symch) begin
                    res_n = 2'd1;
                    if (r_sym_cnt < CW'(MAX_SYMBOL_LEN)) begin
                        n_sym_cnt = r_sym_cnt + CW'(1);
                        res_a     = mk_res(K_SYMCHAR, '0, c, '0);
                    end else begin
                        n_sym_cnt = '0;
                        res_a     = mk_res(K_ERROR, '0, c, '0);
                        n_mode    = LEX_ERROR;
                    end
                end else begin
                    res_a     = mk_res(K_SYMEND, '0, '0, 7'(r_sym_cnt));
                    res_n     = idle_hit ? 2'd2 : 2'd1;
                    n_mode    = idle_mode;
                    n_acc     = idle_acc;
                    n_sym_cnt = idle_cnt;
                end
            end
            LEX_ERROR: begin
                if (c == CH_NUL) begin
                    res_a  = mk_res(K_END, '0, '0, '0);
                    res_n  = 2'd1;
                    n_mode = LEX_IDLE;
                end
            end
            default: begin
                res_n     = idle_hit ? 2'd1 : 2'd0;
                n_mode    = idle_mode;
                n_acc     = idle_acc;
                n_sym_cnt = idle_cnt;
            end
        endcase
        // mark the final item of this byte
        if (res_n == 2'd1) begin
            res_a.last = 1'b1;
        end
        res_b.last = 1'b1;
        if (!accept) begin
            n_mode    = r_mode;
            n_acc     = r_acc;
            n_sym_cnt = r_sym_cnt;
            res_n     = 2'd0;
        end
    end

    // result queue pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(res_n);
        n_rd_ptr = r_rd_ptr + PW'(pop);
        n_count  = r_count + QW'(res_n) - QW'(pop);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= LEX_IDLE;
            r_acc     <= '0;
            r_sym_cnt <= '0;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_count   <= '0;
        end else begin
            r_mode    <= n_mode;
            r_acc     <= n_acc;
            r_sym_cnt <= n_sym_cnt;
            r_wr_ptr  <= n_wr_ptr;
            r_rd_ptr  <= n_rd_ptr;
            r_count   <= n_count;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (res_n != 2'd0) begin
            r_queue[r_wr_ptr] <= res_a;
        end
        if (res_n == 2'd2) begin
            r_queue[r_wr_ptr + PW'(1)] <= res_b;
        end
    end

    // channel outputs
    assign i_char.ready        = (r_count <= QW'(RQ_DEPTH - 2));
    assign o_tok.valid         = (r_count != '0);
    assign o_tok.kind          = r_queue[r_rd_ptr].kind;
    assign o_tok.number_value  = r_queue[r_rd_ptr].number_value;
    assign o_tok.symbol_char   = r_queue[r_rd_ptr].symbol_char;
    assign o_tok.symbol_length = r_queue[r_rd_ptr].symbol_length;
    assign o_tok.last          = r_queue[r_rd_ptr].last;

    // checks
    `ASSERT_ALWAYS(a_queue_bound, i_clk, i_rst_n, r_count <= QW'(RQ_DEPTH))
    `ASSERT_IMPLY(a_acc_idle, i_clk, i_rst_n, r_mode != LEX_NUMBER, r_acc == '0)
    `ASSERT_IMPLY(a_cnt_number, i_clk, i_rst_n, r_mode == LEX_NUMBER, r_sym_cnt == '0)
    `ASSERT_IMPLY(a_cnt_symbol, i_clk, i_rst_n, r_mode == LEX_SYMBOL, r_sym_cnt != '0)

endmodule

[tb/tb_sexpr_tokenizer_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sexpr_tokenizer_unit
// self-checking bench for the s-expression lexer
// ----------------------------------------------------------------------------
// A queue of text bytes (a short hand-written part, a symbol at the length limit
// and one over it, then randomly built token streams with noise) feeds a clocked driver.
// Every byte the lexer takes is run through a behavioral lexer in the bench,
// which queues the token items it should give. Each token item the lexer
// emits is compared field by field with the oldest queued one. Both sides
// stall at random, with a calm stretch and one long hold on the token side.
// ----------------------------------------------------------------------------
module tb_sexpr_tokenizer_unit;
    import sexl_pkg::*;

    localparam real CLK_PERIOD  = 8.0;
    localparam int  SYM_LIMIT   = MAX_SYMBOL_LEN_DEF;
    localparam int  RANDOM_LEN  = 1100;
    localparam int  HOLD_CYCLES = 120;
    localparam int  MAX_REPORTS = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sexl_in_if  char_if ();
    sexl_out_if tok_if ();

    sexpr_tokenizer_unit #(
        .MAX_SYMBOL_LEN (SYM_LIMIT)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if),
        .o_tok   (tok_if)
    );

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    // text bytes waiting to be driven and token items waiting to arrive
    logic [7:0] pending_bytes[$];
    t_result    expected_tokens[$];

    // behavioral lexer state
    t_lex_mode   lex_state = LEX_IDLE;
    logic [30:0] num_acc = '0;
    int          sym_count = 0;

    int error_count = 0;
    int bytes_sent = 0;
    int hold_left = 0;
    bit hold_used = 1'b0;

    // calm stretch: neither side idles while these bytes go through
    wire calm = (bytes_sent >= 500) && (bytes_sent < 750);

    task automatic flag_error(string msg);
        if (error_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_sym_start(logic [7:0] c);
        return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z) ||
               c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH;
    endfunction

    function automatic void push_token(t_kind k, logic [30:0] num, logic [7:0] ch,
                                       logic [6:0] len);
        t_result r;
        r.kind          = k;
        r.number_value  = num;
        r.symbol_char   = ch;
        r.symbol_length = len;
        r.last          = 1'b0;
        expected_tokens.push_back(r);
    endfunction

    // lexing of a byte that starts fresh, no token open
    function automatic void lex_from_idle(logic [7:0] c);
        if (c == CH_NUL) begin
            push_token(K_END, '0, '0, '0);
        end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            // white space is dropped
        end else if (c == CH_LPAREN) begin
            push_token(K_LPAREN, '0, '0, '0);
        end else if (c == CH_RPAREN) begin
            push_token(K_RPAREN, '0, '0, '0);
        end else if (c == CH_DOT) begin
            push_token(K_DOT, '0, '0, '0);
        end else if (c == CH_QUOTE) begin
            push_token(K_QUOTE, '0, '0, '0);
        end else if (is_digit(c)) begin
            num_acc   = 31'(c - CH_ZERO);
            lex_state = LEX_NUMBER;
        end else if (is_sym_start(c)) begin
            push_token(K_SYMCHAR, '0, c, '0);
            sym_count = 1;
            lex_state = LEX_SYMBOL;
        end else begin
            push_token(K_ERROR, '0, c, '0);
            lex_state = LEX_ERROR;
        end
    endfunction

    // expected token items for one accepted text byte
    function automatic void predict_tokens(logic [7:0] c);
        int          first;
        logic [35:0] grown;
        t_result     tail;
        first = expected_tokens.size();
        case (lex_state)
            LEX_NUMBER: begin
                if (is_digit(c)) begin
                    grown   = 36'(num_acc) * 10 + 36'(c - CH_ZERO);
                    num_acc = (grown > 36'(NUM_MAX)) ? NUM_MAX : grown[30:0];
                end else begin
                    push_token(K_INTEGER, num_acc, '0, '0);
                    num_acc   = '0;
                    lex_state = LEX_IDLE;
                    lex_from_idle(c);
                end
            end
            LEX_SYMBOL: begin
                if (is_sym_start(c) || is_digit(c)) begin
                    if (sym_count < SYM_LIMIT) begin
                        sym_count++;
                        push_token(K_SYMCHAR, '0, c, '0);
                    end else begin
                        // overlong symbol: error, no symbol end
                        push_token(K_ERROR, '0, c, '0);
                        sym_count = 0;
                        lex_state = LEX_ERROR;
                    end
                end else begin
                    push_token(K_SYMEND, '0, '0, 7'(sym_count));
                    sym_count = 0;
                    lex_state = LEX_IDLE;
                    lex_from_idle(c);
                end
            end
            LEX_ERROR: begin
                if (c == CH_NUL) begin
                    push_token(K_END, '0, '0, '0);
                    lex_state = LEX_IDLE;
                end
            end
            default: begin
                lex_from_idle(c);
            end
        endcase
        // mark the final item of this byte
        if (expected_tokens.size() > first) begin
            tail      = expected_tokens.pop_back();
            tail.last = 1'b1;
            expected_tokens.push_back(tail);
        end
    endfunction

    function automatic logic [7:0] rand_sym_byte(bit first);
        logic [7:0] signs[4];
        signs = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
        case ($urandom_range(0, first ? 2 : 3))
            0: return CH_UC_A + 8'($urandom_range(0, 25));
            1: return CH_LC_A + 8'($urandom_range(0, 25));
            2: return signs[$urandom_range(0, 3)];
            default: return CH_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            pending_bytes.push_back(s[i]);
    endtask

    task automatic queue_symbol(int len);
        for (int i = 0; i < len; i++)
            pending_bytes.push_back(rand_sym_byte(i == 0));
    endtask

    // text byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_if.valid     <= 1'b0;
            char_if.char_code <= '0;
        end else begin
            if (char_if.valid && char_if.ready)
                bytes_sent <= bytes_sent + 1;
            if (!char_if.valid || char_if.ready) begin
                if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 37)) begin
                    char_if.valid     <= 1'b1;
                    char_if.char_code <= pending_bytes.pop_front();
                end else begin
                    char_if.valid <= 1'b0;
                end
            end
        end
    end

    // one long hold on the token side once traffic is going
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_used && bytes_sent >= 300) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // token side ready
    always @(posedge i_clk) begin
        if (!i_rst_n)
            tok_if.ready <= 1'b0;
        else
            tok_if.ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 37);
    end

    // prediction on accepted bytes, checking of accepted token items
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            if (char_if.valid && char_if.ready)
                predict_tokens(char_if.char_code);
            if (tok_if.valid && tok_if.ready) begin
                if (expected_tokens.size() == 0) begin
                    flag_error($sformatf("unexpected item kind %0d char %02h",
                                         tok_if.kind, tok_if.symbol_char));
                end else begin
                    want = expected_tokens.pop_front();
                    if (tok_if.kind !== want.kind)
                        flag_error($sformatf("kind %0d, want %0d", tok_if.kind, want.kind));
                    if (tok_if.number_value !== want.number_value)
                        flag_error($sformatf("number_value %0d, want %0d",
                                             tok_if.number_value, want.number_value));
                    if (tok_if.symbol_char !== want.symbol_char)
                        flag_error($sformatf("symbol_char %02h, want %02h",
                                             tok_if.symbol_char, want.symbol_char));
                    if (tok_if.symbol_length !== want.symbol_length)
                        flag_error($sformatf("symbol_length %0d, want %0d",
                                             tok_if.symbol_length, want.symbol_length));
                    if (tok_if.last !== want.last)
                        flag_error($sformatf("last %0b, want %0b (kind %0d)",
                                             tok_if.last, want.last, want.kind));
                end
            end
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int         target;
        int         pick;
        int         len;
        logic [7:0] punct[4];
        punct = '{CH_LPAREN, CH_RPAREN, CH_DOT, CH_QUOTE};

        // unknown byte 255, ignored byte in error mode, end of text
        pending_bytes.push_back(8'hff);
        queue_text("x");
        pending_bytes.push_back(CH_NUL);
        // punctuation, a symbol with signs and digits closed by a dot
        queue_text("(+z9.')");
        // integer overflow closed by a paren
        queue_text("4294967296)");
        // white space, then a symbol closed by end of text
        pending_bytes.push_back(CH_TAB);
        pending_bytes.push_back(CH_CR);
        queue_text("Z/");
        pending_bytes.push_back(CH_NUL);

        // symbol exactly at the limit, then one byte over it
        target = pending_bytes.size() + RANDOM_LEN;
        queue_symbol(SYM_LIMIT);
        pending_bytes.push_back(CH_SPACE);
        queue_symbol(SYM_LIMIT + 1);
        queue_text("q1(");
        pending_bytes.push_back(CH_NUL);

        // random token streams with some noise
        while (pending_bytes.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 14) begin
                pending_bytes.push_back(punct[$urandom_range(0, 3)]);
            end else if (pick < 34) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14)
                                                  : $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    pending_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end else if (pick < 58) begin
                len = ($urandom_range(0, 149) == 0) ? $urandom_range(120, 130)
                                                    : $urandom_range(1, 8);
                queue_symbol(len);
            end else if (pick < 74) begin
                pending_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE
                                        : CH_TAB + 8'($urandom_range(0, 4)));
            end else if (pick < 84) begin
                pending_bytes.push_back(CH_NUL);
            end else begin
                pending_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || char_if.valid)
            @(posedge i_clk);
        while (expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (error_count == 0)
            $display("tb_sexpr_tokenizer_unit: done, clean");
        else
            $display("tb_sexpr_tokenizer_unit: done, errors");
        $finish;
    end

    // run limit
    initial begin
        #(400_000 * CLK_PERIOD);
        $display("tb_sexpr_tokenizer_unit: done, errors");
        $finish;
    end

endmodule
